@@ rtl/psar_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_pkg
// Shared types, constants and the gamma curve table for the sample
// accumulation and resolve unit.
// ----------------------------------------------------------------------------
package psar_pkg;

    localparam int PIXEL_CAPACITY = 65536;
    localparam int GAMMA_ENTRIES  = 1024;

    localparam int ADDR_W   = $clog2(PIXEL_CAPACITY);
    localparam int GIDX_W   = $clog2(GAMMA_ENTRIES);
    localparam int STEP_W   = $clog2(GIDX_W + 1);

    localparam int CMD_W    = 2;
    localparam int COORD_W  = 12;
    localparam int RAD_W    = 16;
    localparam int DIM_W    = 13;
    localparam int SUM_W    = 32;
    localparam int CNT_W    = 16;
    localparam int COL_W    = 16;
    localparam int PROD_W   = COORD_W + DIM_W;
    localparam int OFF_W    = PROD_W + 1;
    localparam int DEN_W    = CNT_W + 12;
    localparam int NUM_CH   = 3;

    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_SPLAT   = 2'd0,
        CMD_RESOLVE = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL,
        S_CHK,
        S_READ,
        S_LOAD,
        S_ACC,
        S_WRITE,
        S_DINIT,
        S_DIV,
        S_GAMMA,
        S_GSTORE,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [NUM_CH-1:0][SUM_W-1:0] sum;
        logic [CNT_W-1:0]             count;
    } t_pix;

    typedef logic [COL_W-1:0] t_gamma_tab [GAMMA_ENTRIES];

    // largest y with y^11 * N^5 <= i^5 * 2^176
    function automatic logic [COL_W-1:0] gamma_entry(input int unsigned i);
        logic [255:0] rhs;
        logic [255:0] lhs;
        int unsigned  lo;
        int unsigned  hi;
        int unsigned  mid;
        int           k;
        rhs = 256'd1;
        for (k = 0; k < 5; k++) rhs = rhs * 256'(i);
        rhs = rhs << 176;
        lo = 0;
        hi = 65535;
        while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            lhs = 256'd1;
            for (k = 0; k < 11; k++) lhs = lhs * 256'(mid);
            for (k = 0; k < 5; k++) lhs = lhs * 256'(GAMMA_ENTRIES);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[COL_W-1:0];
    endfunction

    function automatic t_gamma_tab build_gamma();
        t_gamma_tab t;
        int         i;
        for (i = 0; i < GAMMA_ENTRIES; i++) t[i] = gamma_entry(i);
        return t;
    endfunction

    localparam t_gamma_tab GAMMA_TABLE = build_gamma();

endpackage

@@ rtl/psar_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_in_if
// Command channel: splat, resolve, clear and no-op beats.
// ----------------------------------------------------------------------------
interface psar_in_if;
    logic                          valid;
    logic                          ready;
    logic [psar_pkg::CMD_W-1:0]    cmd;
    logic [psar_pkg::COORD_W-1:0]  pixel_x;
    logic [psar_pkg::COORD_W-1:0]  pixel_y;
    logic [psar_pkg::RAD_W-1:0]    red_radiance;
    logic [psar_pkg::RAD_W-1:0]    green_radiance;
    logic [psar_pkg::RAD_W-1:0]    blue_radiance;

    modport source (output valid, cmd, pixel_x, pixel_y, red_radiance, green_radiance,
                    blue_radiance, input ready);
    modport sink   (input valid, cmd, pixel_x, pixel_y, red_radiance, green_radiance,
                    blue_radiance, output ready);
endinterface

@@ rtl/psar_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psar_out_if
// Result channel: one beat per command.
// ----------------------------------------------------------------------------
interface psar_out_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic                        has_samples;
    logic [psar_pkg::COL_W-1:0]  red_out;
    logic [psar_pkg::COL_W-1:0]  green_out;
    logic [psar_pkg::COL_W-1:0]  blue_out;

    modport source (output valid, status, has_samples, red_out, green_out, blue_out,
                    input ready);
    modport sink   (input valid, status, has_samples, red_out, green_out, blue_out,
                    output ready);
endinterface

@@ rtl/pixel_sample_accumulate_resolve_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_sample_accumulate_resolve_unit
// Per-pixel radiance accumulation store with gamma-corrected resolve.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one command beat: splat adds Q4.12 RGB radiance to a pixel's
//   sums and bumps its sample count, resolve returns the gamma-corrected mean
//   color as Q0.16, clear zeroes the whole store. o_out returns exactly one
//   result beat per command. Image width and height are set over the APB port
//   at byte addresses 0 and 4; the user must write them only while the unit
//   is idle; the block itself does not enforce it. One command is in flight
//   at a time; i_in.ready is high only when idle.
//   Resolve cost is set by a single shared subtract/compare unit: per
//   channel one range check and ten restoring division steps, then one
//   registered gamma table read.
//   Splat cost is set by the single-port pixel memory read-modify-write and
//   the same shared adder, used once per channel.
//   After reset the unit runs a clearing pass over all 65536 words of the
//   pixel memory before it raises i_in.ready.
//   A result is held in the output register until o_out.ready; the next
//   command is not taken before that.
// ----------------------------------------------------------------------------
module pixel_sample_accumulate_resolve_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    psar_in_if.sink                       i_in,
    psar_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psar_pkg::APB_AW-1:0]   paddr,
    input  logic [psar_pkg::APB_DW-1:0]   pwdata,
    output logic [psar_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    psar_pkg::t_state                    r_state, n_state;
    logic [psar_pkg::DIM_W-1:0]          r_width, r_height;
    logic [psar_pkg::ADDR_W-1:0]         r_clr_addr;
    logic                                r_clr_item;

    psar_pkg::t_cmd                      r_cmd;
    logic [psar_pkg::COORD_W-1:0]        r_x, r_y;
    logic [psar_pkg::RAD_W-1:0]          r_rad [psar_pkg::NUM_CH];
    logic [psar_pkg::PROD_W-1:0]         r_prod;
    logic [psar_pkg::ADDR_W-1:0]         r_off;
    psar_pkg::t_pix                      r_rd_q, r_word;
    logic [1:0]                          r_ch;
    logic [psar_pkg::STEP_W-1:0]         r_step;
    logic [psar_pkg::SUM_W-1:0]          r_rem;
    logic [psar_pkg::DEN_W-1:0]          r_den;
    logic [psar_pkg::GIDX_W-1:0]         r_quot;
    logic [psar_pkg::COL_W-1:0]          r_gam_q;
    logic                                r_status, r_has;
    logic [psar_pkg::COL_W-1:0]          r_col [psar_pkg::NUM_CH];

    psar_pkg::t_pix                      mem [psar_pkg::PIXEL_CAPACITY];
    logic                                mem_we;
    logic [psar_pkg::ADDR_W-1:0]         mem_addr;
    psar_pkg::t_pix                      mem_wdata;

    logic [psar_pkg::SUM_W:0]            alu_a, alu_b, alu_res;
    logic                                alu_sub, alu_ge;
    logic [psar_pkg::OFF_W-1:0]          off;
    logic                                oob;
    logic                                in_acc, cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= psar_pkg::DIM_W'(256);
            r_height <= psar_pkg::DIM_W'(256);
        end else if (cfg_wr) begin
            if (paddr[2] == psar_pkg::REG_WIDTH) r_width <= pwdata[psar_pkg::DIM_W-1:0];
            else r_height <= pwdata[psar_pkg::DIM_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == psar_pkg::REG_WIDTH)
            prdata = {(psar_pkg::APB_DW - psar_pkg::DIM_W)'(0), r_width};
        else
            prdata = {(psar_pkg::APB_DW - psar_pkg::DIM_W)'(0), r_height};
    end

    // ---------------- shared add/subtract unit ----------------
    always_comb begin
        alu_a   = {1'b0, r_rem};
        alu_b   = {(psar_pkg::SUM_W + 1 - psar_pkg::DEN_W)'(0), r_den};
        alu_sub = 1'b1;
        if (r_state == psar_pkg::S_ACC) begin
            alu_a   = {1'b0, r_word.sum[r_ch]};
            alu_b   = {(psar_pkg::SUM_W + 1 - psar_pkg::RAD_W)'(0), r_rad[r_ch]};
            alu_sub = 1'b0;
        end
    end

    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign alu_ge  = !alu_res[psar_pkg::SUM_W];

    assign off = {(psar_pkg::OFF_W - psar_pkg::COORD_W)'(0), r_x}
               + {1'b0, r_prod};
    assign oob = ({1'b0, r_x} >= r_width) || ({1'b0, r_y} >= r_height)
              || (off >= psar_pkg::OFF_W'(psar_pkg::PIXEL_CAPACITY));

    assign in_acc = i_in.valid && i_in.ready;

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            psar_pkg::S_CLEAR: begin
                if (r_clr_addr == '1) n_state = r_clr_item ? psar_pkg::S_OUT : psar_pkg::S_IDLE;
            end
            psar_pkg::S_IDLE: begin
                if (in_acc) begin
                    case (psar_pkg::t_cmd'(i_in.cmd))
                        psar_pkg::CMD_SPLAT, psar_pkg::CMD_RESOLVE: n_state = psar_pkg::S_MUL;
                        psar_pkg::CMD_CLEAR: n_state = psar_pkg::S_CLEAR;
                        default:             n_state = psar_pkg::S_OUT;
                    endcase
                end
            end
            psar_pkg::S_MUL:   n_state = psar_pkg::S_CHK;
            psar_pkg::S_CHK:   n_state = oob ? psar_pkg::S_OUT : psar_pkg::S_READ;
            psar_pkg::S_READ:  n_state = psar_pkg::S_LOAD;
            psar_pkg::S_LOAD: begin
                if (r_cmd == psar_pkg::CMD_SPLAT) n_state = psar_pkg::S_ACC;
                else if (r_rd_q.count == '0) n_state = psar_pkg::S_OUT;
                else n_state = psar_pkg::S_DINIT;
            end
            psar_pkg::S_ACC: begin
                if (r_ch == 2'd2) n_state = psar_pkg::S_WRITE;
            end
            psar_pkg::S_WRITE: n_state = psar_pkg::S_OUT;
            psar_pkg::S_DINIT: n_state = psar_pkg::S_DIV;
            psar_pkg::S_DIV: begin
                if ((r_step == '0 && alu_ge) || r_step == psar_pkg::STEP_W'(psar_pkg::GIDX_W))
                    n_state = psar_pkg::S_GAMMA;
            end
            psar_pkg::S_GAMMA:  n_state = psar_pkg::S_GSTORE;
            psar_pkg::S_GSTORE: n_state = (r_ch == 2'd2) ? psar_pkg::S_OUT : psar_pkg::S_DINIT;
            psar_pkg::S_OUT: begin
                if (o_out.ready) n_state = psar_pkg::S_IDLE;
            end
            default: n_state = psar_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = (r_state == psar_pkg::S_IDLE);
        o_out.valid = (r_state == psar_pkg::S_OUT);
        mem_we      = (r_state == psar_pkg::S_CLEAR) || (r_state == psar_pkg::S_WRITE);
        mem_addr    = (r_state == psar_pkg::S_CLEAR) ? r_clr_addr : r_off;
        mem_wdata   = (r_state == psar_pkg::S_CLEAR) ? '0 : r_word;
    end

    assign o_out.status      = r_status;
    assign o_out.has_samples = r_has;
    assign o_out.red_out     = r_col[0];
    assign o_out.green_out   = r_col[1];
    assign o_out.blue_out    = r_col[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= psar_pkg::S_CLEAR;
            r_clr_addr <= '0;
            r_clr_item <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == psar_pkg::S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else if (in_acc) begin
                r_clr_addr <= '0;
                r_clr_item <= 1'b1;
            end
        end
    end

    // ---------------- pixel memory ----------------
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_addr] <= mem_wdata;
        r_rd_q <= mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        r_gam_q <= psar_pkg::GAMMA_TABLE[r_quot];
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            psar_pkg::S_IDLE: begin
                if (in_acc) begin
                    r_cmd    <= psar_pkg::t_cmd'(i_in.cmd);
                    r_x      <= i_in.pixel_x;
                    r_y      <= i_in.pixel_y;
                    r_rad[0] <= i_in.red_radiance;
                    r_rad[1] <= i_in.green_radiance;
                    r_rad[2] <= i_in.blue_radiance;
                    r_status <= 1'b0;
                    r_has    <= 1'b0;
                    r_col[0] <= '0;
                    r_col[1] <= '0;
                    r_col[2] <= '0;
                end
            end
            psar_pkg::S_MUL: begin
                r_prod <= psar_pkg::PROD_W'(r_y) * psar_pkg::PROD_W'(r_width);
            end
            psar_pkg::S_CHK: begin
                r_off <= off[psar_pkg::ADDR_W-1:0];
                if (oob) r_status <= 1'b1;
            end
            psar_pkg::S_LOAD: begin
                r_word <= r_rd_q;
                r_ch   <= 2'd0;
            end
            psar_pkg::S_ACC: begin
                // saturate each channel sum on carry out
                r_word.sum[r_ch] <= alu_res[psar_pkg::SUM_W] ? '1
                                    : alu_res[psar_pkg::SUM_W-1:0];
                r_ch <= r_ch + 2'd1;
                if (r_ch == 2'd2 && r_word.count != '1)
                    r_word.count <= r_word.count + 1'b1;
            end
            psar_pkg::S_DINIT: begin
                r_rem  <= r_word.sum[r_ch];
                r_den  <= {r_word.count, 12'd0};
                r_step <= '0;
                r_quot <= '0;
            end
            psar_pkg::S_DIV: begin
                r_step <= r_step + 1'b1;
                r_den  <= r_den >> 1;
                if (r_step == '0) begin
                    // mean at or above one: cap at the last table entry
                    if (alu_ge) r_quot <= '1;
                end else begin
                    if (alu_ge) r_rem <= alu_res[psar_pkg::SUM_W-1:0];
                    r_quot <= {r_quot[psar_pkg::GIDX_W-2:0], alu_ge};
                end
            end
            psar_pkg::S_GSTORE: begin
                r_col[r_ch] <= r_gam_q;
                r_ch        <= r_ch + 2'd1;
                if (r_ch == 2'd2) r_has <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    // ---------------- assertions ----------------
    a_no_take_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input taken while a result is pending");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("second beat taken back to back");

    a_has_ok_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.has_samples) |-> !o_out.status)
        else $error("samples reported for an out of range pixel");

    a_oob_zero_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |->
        (o_out.red_out == '0 && o_out.green_out == '0 && o_out.blue_out == '0))
        else $error("color on an ignored pixel");

endmodule

@@ tb/tb_pixel_sample_accumulate_resolve_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_sample_accumulate_resolve_unit
// Self-checking bench for the sample accumulation and resolve unit.
// Queued command beats pass through a driver with random gaps. A monitor
// predicts one result per accepted beat from a private copy of the pixel
// store, the image size and an independently built gamma curve. It checks
// every result beat against the oldest prediction. The run walks through
// several image sizes written over APB, including the extremes.
// ----------------------------------------------------------------------------
module tb_pixel_sample_accumulate_resolve_unit;

    typedef struct {
        psar_pkg::t_cmd   cmd;
        logic [11:0]      px;
        logic [11:0]      py;
        logic [15:0]      rad [3];
    } t_beat;

    typedef struct packed {
        logic             status;
        logic             has_samples;
        logic [15:0]      red;
        logic [15:0]      green;
        logic [15:0]      blue;
    } t_result;

    typedef struct {
        logic [31:0]      sum [3];
        logic [15:0]      count;
    } t_pixel_acc;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [psar_pkg::APB_AW-1:0] paddr;
    logic [psar_pkg::APB_DW-1:0] pwdata;
    logic [psar_pkg::APB_DW-1:0] prdata;
    logic pready;

    psar_in_if  in_if ();
    psar_out_if out_if ();

    pixel_sample_accumulate_resolve_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_beat            pending_beats [$];
    t_result          expected_results [$];
    t_pixel_acc       pixel_store [int unsigned];
    logic [15:0]      gamma_curve [psar_pkg::GAMMA_ENTRIES];
    logic [12:0]      img_width;
    logic [12:0]      img_height;
    logic             beat_taken;
    logic             no_gaps;
    int               mismatches;
    longint           cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // y^11 * 2^50 <= i^5 * 2^176, built one bit at a time from the top
    initial begin
        logic [255:0] lim;
        logic [255:0] pw;
        logic [15:0]  y;
        logic [15:0]  t;
        for (int i = 0; i < psar_pkg::GAMMA_ENTRIES; i++) begin
            lim = 256'd1;
            for (int k = 0; k < 5; k++) lim = lim * 256'(i);
            lim = lim << 126;
            y = '0;
            for (int b = 15; b >= 0; b--) begin
                t = y | (16'd1 << b);
                pw = 256'd1;
                for (int k = 0; k < 11; k++) pw = pw * 256'(t);
                if (pw <= lim) y = t;
            end
            gamma_curve[i] = y;
        end
    end

    function automatic logic [15:0] gamma_of(logic [31:0] sum, logic [15:0] count);
        logic [63:0] idx;
        idx = (64'(sum) * psar_pkg::GAMMA_ENTRIES) / (64'(count) << 12);
        if (idx > psar_pkg::GAMMA_ENTRIES - 1) idx = psar_pkg::GAMMA_ENTRIES - 1;
        return gamma_curve[idx];
    endfunction

    function automatic t_result predict_pixel_result(t_beat b);
        t_result     r;
        logic [31:0] off;
        logic [32:0] s;
        t_pixel_acc  p;
        r = '0;
        if (b.cmd == psar_pkg::CMD_CLEAR) begin
            pixel_store.delete();
            return r;
        end
        if (b.cmd == psar_pkg::CMD_NOP) return r;
        off = 32'(b.px) + 32'(b.py) * 32'(img_width);
        if (b.px >= img_width || b.py >= img_height || off >= psar_pkg::PIXEL_CAPACITY) begin
            r.status = 1'b1;
            return r;
        end
        if (pixel_store.exists(off)) p = pixel_store[off];
        else begin
            p.sum = '{default: 32'd0};
            p.count = 16'd0;
        end
        if (b.cmd == psar_pkg::CMD_SPLAT) begin
            for (int c = 0; c < 3; c++) begin
                s = 33'(p.sum[c]) + 33'(b.rad[c]);
                p.sum[c] = s[32] ? 32'hFFFF_FFFF : s[31:0];
            end
            if (p.count != 16'hFFFF) p.count++;
            pixel_store[off] = p;
        end else if (p.count != 0) begin
            r.has_samples = 1'b1;
            r.red   = gamma_of(p.sum[0], p.count);
            r.green = gamma_of(p.sum[1], p.count);
            r.blue  = gamma_of(p.sum[2], p.count);
        end
        return r;
    endfunction

    // driver: inputs change on the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= no_gaps || ($urandom_range(0, 99) >= 36);
            if (!in_if.valid || beat_taken) begin
                if (pending_beats.size() != 0 &&
                    (no_gaps || $urandom_range(0, 99) >= 36)) begin
                    in_if.valid          <= 1'b1;
                    in_if.cmd            <= pending_beats[0].cmd;
                    in_if.pixel_x        <= pending_beats[0].px;
                    in_if.pixel_y        <= pending_beats[0].py;
                    in_if.red_radiance   <= pending_beats[0].rad[0];
                    in_if.green_radiance <= pending_beats[0].rad[1];
                    in_if.blue_radiance  <= pending_beats[0].rad[2];
                    void'(pending_beats.pop_front());
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: sample on the rising edge
    always @(posedge i_clk) begin
        t_beat   b;
        t_result got;
        t_result want;
        beat_taken = 1'b0;
        cycle_count++;
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) begin
                beat_taken = 1'b1;
                b.cmd = psar_pkg::t_cmd'(in_if.cmd);
                b.px = in_if.pixel_x;
                b.py = in_if.pixel_y;
                b.rad[0] = in_if.red_radiance;
                b.rad[1] = in_if.green_radiance;
                b.rad[2] = in_if.blue_radiance;
                expected_results.push_back(predict_pixel_result(b));
            end
            if (out_if.valid && out_if.ready) begin
                got = {out_if.status, out_if.has_samples, out_if.red_out,
                       out_if.green_out, out_if.blue_out};
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("result beat with none expected: %p", got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected st=%0d hs=%0d rgb=%h/%h/%h",
                                     want.status, want.has_samples, want.red, want.green,
                                     want.blue, " got st=%0d hs=%0d rgb=%h/%h/%h",
                                     got.status, got.has_samples, got.red,
                                     got.green, got.blue);
                    end
                end
            end
        end
        if (cycle_count > 64'd4000000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic reg_write(logic [psar_pkg::APB_AW-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_image_size(logic [12:0] w, logic [12:0] h);
        reg_write(3'd0, 32'(w));
        reg_write(3'd4, 32'(h));
        img_width = w;
        img_height = h;
    endtask

    task automatic queue_beat(psar_pkg::t_cmd c, logic [11:0] x, logic [11:0] y,
                              logic [15:0] r, logic [15:0] g, logic [15:0] bl);
        t_beat b;
        b.cmd = c;
        b.px = x;
        b.py = y;
        b.rad[0] = r;
        b.rad[1] = g;
        b.rad[2] = bl;
        pending_beats.push_back(b);
    endtask

    // hold until every queued beat is sent and every result is back
    task automatic drain();
        while (pending_beats.size() != 0 || in_if.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic random_phase(int n_beats);
        logic [11:0]    hot_x [6];
        logic [11:0]    hot_y [6];
        logic [11:0]    x, y;
        int             sel, clear_at;
        psar_pkg::t_cmd c;
        for (int k = 0; k < 6; k++) begin
            hot_x[k] = (img_width == 0) ? 12'd0 : 12'($urandom_range(0, img_width - 1));
            hot_y[k] = (img_height == 0) ? 12'd0 : 12'($urandom_range(0, img_height - 1));
        end
        clear_at = $urandom_range(n_beats / 2, n_beats - 1);
        for (int n = 0; n < n_beats; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                x = hot_x[n % 6];
                y = hot_y[n % 6];
            end else if (sel < 85) begin
                x = 12'($urandom_range(0, img_width == 0 ? 0 : img_width - 1));
                y = 12'($urandom_range(0, img_height == 0 ? 0 : img_height - 1));
            end else begin
                x = 12'($urandom);
                y = 12'($urandom);
            end
            sel = $urandom_range(0, 99);
            c = (sel < 55) ? psar_pkg::CMD_SPLAT
              : (sel < 96) ? psar_pkg::CMD_RESOLVE : psar_pkg::CMD_NOP;
            if (n == clear_at) c = psar_pkg::CMD_CLEAR;
            sel = $urandom_range(0, 9);
            queue_beat(c, x, y, sel == 0 ? 16'hFFFF : 16'($urandom),
                       sel == 1 ? 16'h0000 : 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin
        logic [12:0] widths  [7];
        logic [12:0] heights [7];
        widths  = '{13'd1, 13'd4096, 13'd8191, 13'd0, 13'd37, 13'd4096, 13'd13};
        heights = '{13'd1, 13'd4096, 13'd8191, 13'd3, 13'd5, 13'd16, 13'd8191};
        in_if.valid = 1'b0;
        in_if.cmd = psar_pkg::CMD_NOP;
        in_if.pixel_x = '0;
        in_if.pixel_y = '0;
        in_if.red_radiance = '0;
        in_if.green_radiance = '0;
        in_if.blue_radiance = '0;
        out_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        beat_taken = 1'b0;
        no_gaps = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        img_width = 13'd256;
        img_height = 13'd256;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        // wait out the clearing pass
        while (!in_if.ready) @(posedge i_clk);

        // directed: defaults 256x256
        queue_beat(psar_pkg::CMD_RESOLVE, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_beat(psar_pkg::CMD_SPLAT, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_beat(psar_pkg::CMD_SPLAT, 12'd0, 12'd0, 16'hFFFF, 16'h0000, 16'h1000);
        queue_beat(psar_pkg::CMD_RESOLVE, 12'd0, 12'd0, 16'h0000, 16'h0000, 16'h0000);
        queue_beat(psar_pkg::CMD_SPLAT, 12'd255, 12'd255, 16'h0000, 16'h0000, 16'h0000);
        queue_beat(psar_pkg::CMD_RESOLVE, 12'd255, 12'd255, 16'h0, 16'h0, 16'h0);
        queue_beat(psar_pkg::CMD_SPLAT, 12'd7, 12'd3, 16'h0800, 16'h0001, 16'h0FFF);
        queue_beat(psar_pkg::CMD_RESOLVE, 12'd7, 12'd3, 16'hAAAA, 16'h5555, 16'h0);
        queue_beat(psar_pkg::CMD_SPLAT, 12'd256, 12'd0, 16'h1000, 16'h1000, 16'h1000);
        queue_beat(psar_pkg::CMD_RESOLVE, 12'd0, 12'd256, 16'h0, 16'h0, 16'h0);
        queue_beat(psar_pkg::CMD_RESOLVE, 12'hFFF, 12'hFFF, 16'h0, 16'h0, 16'h0);
        queue_beat(psar_pkg::CMD_NOP, 12'd0, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_beat(psar_pkg::CMD_CLEAR, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_beat(psar_pkg::CMD_RESOLVE, 12'd0, 12'd0, 16'h0, 16'h0, 16'h0);
        queue_beat(psar_pkg::CMD_RESOLVE, 12'd7, 12'd3, 16'h0, 16'h0, 16'h0);
        drain();
        random_phase(150);
        drain();

        for (int p = 0; p < 7; p++) begin
            set_image_size(widths[p], heights[p]);
            no_gaps = (p == 2);
            random_phase(80);
            drain();
            random_phase(80);
            drain();
        end
        no_gaps = 1'b0;

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/psar_pkg.sv
rtl/psar_in_if.sv
rtl/psar_out_if.sv
rtl/pixel_sample_accumulate_resolve_unit.sv
tb/tb_pixel_sample_accumulate_resolve_unit.sv
